/* sv/assert_macros.svh */
// Assertion macros shared by the checker files of the array list engine.
// Needs nothing else; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ALE_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("array list engine assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ALE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("array list engine assertion failed");

`endif

/* sv/ale_pkg.sv */
// Shared types for the array list engine: command, status and sequencer codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT,
    S_REV,
    S_PUT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* sv/array_list_engine_top.sv */
// Array list engine top level: entry memory, sequencer and output register.
// Depends on ale_pkg.
//
// Usage: the input channel (in_valid/in_stall) carries one command beat with
// in_command, in_position and in_value. The result channel (out_valid/out_stall)
// returns one beat per command with out_data_out, out_count and out_status.
// One command is worked on at a time; in_stall is high from the cycle after
// acceptance until the result is loaded into the output register.
// Every entry move goes through the single memory read port and single write
// port, one entry per cycle. Insert shifts the entries from the position up and
// then writes the value; remove shifts the entries above the position down;
// reverse swaps pairs from both ends; a read or failed command moves nothing.
// The next beat can be taken once the result loads. While the previous result
// waits in the output register a new command is taken; the sequencer holds in
// its final step until that register is free. Reset (synchronous, active low)
// empties the list and drops any pending result; memory contents are not
// cleared.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine_top #(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_data_out,
  output logic [7:0]         out_count,
  output logic [1:0]         out_status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  ale_pkg::state_t  state_r, state_nxt;
  ale_pkg::cmd_t    cmd_r, cmd_nxt;
  ale_pkg::status_t status_r, status_nxt, in_status;

  logic [AW-1:0] pos_r, pos_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [31:0]   data_r, data_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] whi_r, whi_nxt;
  logic          phase_r, phase_nxt;
  logic [31:0]   tmp_r, tmp_nxt;
  logic [31:0]   rdata_r;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic [7:0]    out_count_r, out_count_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] mem_ra;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;

  logic          accept;
  logic          out_free;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] pos_x;
  logic [CW-1:0] cnt_new;
  logic [XW-1:0] cnt_new_x;
  ale_pkg::cmd_t in_cmd;

  assign in_stall     = (state_r != ale_pkg::S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign cnt_x        = XW'(cnt_r);
  assign pos_x        = XW'(in_position);
  assign in_cmd       = ale_pkg::cmd_t'(in_command);
  assign cnt_new_x    = XW'(cnt_new);

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_count    = out_count_r;
  assign out_status   = out_status_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  always_comb begin
    in_status = ale_pkg::ST_OK;
    case (in_cmd)
      ale_pkg::CMD_INSERT: begin
        if (pos_x > cnt_x) begin
          in_status = ale_pkg::ST_RANGE;
        end else if (cnt_x == XW'(DEPTH)) begin
          in_status = ale_pkg::ST_FULL;
        end
      end
      ale_pkg::CMD_REMOVE, ale_pkg::CMD_READ: begin
        if (pos_x >= cnt_x) begin
          in_status = ale_pkg::ST_RANGE;
        end
      end
      default: in_status = ale_pkg::ST_OK;
    endcase
  end

  always_comb begin
    cnt_new = cnt_r;
    if (status_r == ale_pkg::ST_OK) begin
      if (cmd_r == ale_pkg::CMD_INSERT) begin
        cnt_new = cnt_r + CW'(1);
      end else if (cmd_r == ale_pkg::CMD_REMOVE) begin
        cnt_new = cnt_r - CW'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ale_pkg::S_IDLE: begin
        if (accept) state_nxt = ale_pkg::S_FETCH;
      end
      ale_pkg::S_FETCH: begin
        if (status_r != ale_pkg::ST_OK) begin
          state_nxt = ale_pkg::S_DONE;
        end else begin
          case (cmd_r)
            ale_pkg::CMD_INSERT, ale_pkg::CMD_REMOVE: state_nxt = ale_pkg::S_SHIFT;
            ale_pkg::CMD_REVERSE:                     state_nxt = ale_pkg::S_REV;
            default:                                  state_nxt = ale_pkg::S_DONE;
          endcase
        end
      end
      ale_pkg::S_SHIFT: begin
        if (left_r == '0 && !pend_r) begin
          state_nxt = (cmd_r == ale_pkg::CMD_INSERT) ? ale_pkg::S_PUT : ale_pkg::S_DONE;
        end
      end
      ale_pkg::S_REV: begin
        if (!phase_r && !pend_r && left_r == '0) state_nxt = ale_pkg::S_DONE;
      end
      ale_pkg::S_PUT:  state_nxt = ale_pkg::S_DONE;
      ale_pkg::S_DONE: begin
        if (out_free) state_nxt = ale_pkg::S_IDLE;
      end
      default: state_nxt = ale_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    status_nxt     = status_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    data_nxt       = data_r;
    cnt_nxt        = cnt_r;
    left_nxt       = left_r;
    src_nxt        = src_r;
    wa_nxt         = wa_r;
    pend_nxt       = pend_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    whi_nxt        = whi_r;
    phase_nxt      = phase_r;
    tmp_nxt        = tmp_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    mem_ra         = src_r;
    mem_we         = 1'b0;
    mem_wa         = wa_r;
    mem_wd         = rdata_r;

    case (state_r)
      ale_pkg::S_IDLE: begin
        mem_ra = pos_x[AW-1:0];
        if (accept) begin
          cmd_nxt    = in_cmd;
          status_nxt = in_status;
          pos_nxt    = pos_x[AW-1:0];
          val_nxt    = in_value;
        end
      end
      ale_pkg::S_FETCH: begin
        pend_nxt  = 1'b0;
        phase_nxt = 1'b0;
        if ((cmd_r == ale_pkg::CMD_REMOVE || cmd_r == ale_pkg::CMD_READ) &&
            status_r == ale_pkg::ST_OK) begin
          data_nxt = rdata_r;
        end else begin
          data_nxt = '0;
        end
        case (cmd_r)
          ale_pkg::CMD_INSERT: begin
            src_nxt  = cnt_r[AW-1:0] - AW'(1);
            left_nxt = cnt_r - CW'(pos_r);
          end
          ale_pkg::CMD_REVERSE: begin
            lo_nxt   = '0;
            hi_nxt   = cnt_r[AW-1:0] - AW'(1);
            left_nxt = cnt_r >> 1;
          end
          default: begin
            src_nxt  = pos_r + AW'(1);
            left_nxt = cnt_r - CW'(pos_r) - CW'(1);
          end
        endcase
      end
      ale_pkg::S_SHIFT: begin
        mem_ra = src_r;
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = wa_r;
          mem_wd = rdata_r;
        end
        if (left_r != '0) begin
          pend_nxt = 1'b1;
          left_nxt = left_r - CW'(1);
          if (cmd_r == ale_pkg::CMD_INSERT) begin
            wa_nxt  = src_r + AW'(1);
            src_nxt = src_r - AW'(1);
          end else begin
            wa_nxt  = src_r - AW'(1);
            src_nxt = src_r + AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
        end
      end
      ale_pkg::S_REV: begin
        phase_nxt = !phase_r;
        if (!phase_r) begin
          mem_ra = lo_r;
          if (pend_r) begin
            mem_we = 1'b1;
            mem_wa = wa_r;
            mem_wd = rdata_r;
          end
        end else begin
          mem_ra  = hi_r;
          tmp_nxt = rdata_r;
          if (pend_r) begin
            mem_we = 1'b1;
            mem_wa = whi_r;
            mem_wd = tmp_r;
          end
          if (left_r != '0) begin
            pend_nxt = 1'b1;
            wa_nxt   = lo_r;
            whi_nxt  = hi_r;
            lo_nxt   = lo_r + AW'(1);
            hi_nxt   = hi_r - AW'(1);
            left_nxt = left_r - CW'(1);
          end else begin
            pend_nxt = 1'b0;
          end
        end
      end
      ale_pkg::S_PUT: begin
        mem_we = 1'b1;
        mem_wa = pos_r;
        mem_wd = val_r;
      end
      ale_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = data_r;
          out_count_nxt  = cnt_new_x[7:0];
          out_status_nxt = status_r;
          cnt_nxt        = cnt_new;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ale_pkg::S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    status_r     <= status_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    data_r       <= data_nxt;
    left_r       <= left_nxt;
    src_r        <= src_nxt;
    wa_r         <= wa_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    whi_r        <= whi_nxt;
    tmp_r        <= tmp_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire

/* sv/ale_checker.sv */
// Port-level checker for the array list engine, bound to the top level.
// Depends on ale_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ale_checker #(
  parameter int DEPTH = 128
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_data_out,
  input wire logic [7:0]         out_count,
  input wire logic [1:0]         out_status
);

  localparam logic [7:0] FullCount = 8'(DEPTH);

  logic        in_beat;
  logic        out_held;
  logic        out_failed;
  logic        out_full;
  logic [41:0] out_payload;

  assign in_beat     = in_valid && !in_stall;
  assign out_held    = out_valid && out_stall;
  assign out_failed  = out_valid && (out_status != ale_pkg::ST_OK);
  assign out_full    = out_valid && (out_status == ale_pkg::ST_FULL);
  assign out_payload = {out_data_out, out_count, out_status};

  `ALE_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_beat, in_stall)
  `ALE_ASSERT_IMPL(a_fail_no_data, clk, rst_n, out_failed, out_data_out == 32'sd0)
  `ALE_ASSERT_IMPL(a_full_count, clk, rst_n, out_full, out_count == FullCount)
  `ALE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_payload))

endmodule

bind array_list_engine_top ale_checker #(.DEPTH(DEPTH)) u_ale_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_data_out (out_data_out),
  .out_count    (out_count),
  .out_status   (out_status)
);

`default_nettype wire

/* verif/array_list_engine_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for array_list_engine_top: a directed table, then random
// fill and drain passes, each beat checked against the table or a bench list model.
// Depends on ale_pkg and array_list_engine_top.
module array_list_engine_top_tb;

  localparam int DEPTH = 128;
  localparam int RANDOM_ITEMS = 1375;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = DEPTH + 40;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int ROWS = 25;

  typedef struct packed {
    logic signed [31:0] data;
    logic [7:0]         count;
    ale_pkg::status_t   status;
  } list_result_t;

  typedef struct packed {
    ale_pkg::cmd_t      cmd;
    logic [6:0]         pos;
    logic signed [31:0] val;
    logic               typed;
    list_result_t       res;
  } directed_row_t;

  localparam list_result_t UNTYPED = '{32'sd0, 8'd0, ale_pkg::ST_OK};

  localparam directed_row_t DIRECTED_ROWS [0:ROWS-1] = '{
    '{ale_pkg::CMD_READ,    7'd0,   32'sd0,        1'b1, '{32'sd0, 8'd0, ale_pkg::ST_RANGE}},
    '{ale_pkg::CMD_REMOVE,  7'd0,   32'sd17,       1'b1, '{32'sd0, 8'd0, ale_pkg::ST_RANGE}},
    '{ale_pkg::CMD_REVERSE, 7'd0,   32'sd0,        1'b1, '{32'sd0, 8'd0, ale_pkg::ST_OK}},
    '{ale_pkg::CMD_INSERT,  7'd1,   32'sd5,        1'b1, '{32'sd0, 8'd0, ale_pkg::ST_RANGE}},
    '{ale_pkg::CMD_INSERT,  7'd127, -32'sd1,       1'b1, '{32'sd0, 8'd0, ale_pkg::ST_RANGE}},
    '{ale_pkg::CMD_INSERT,  7'd0,   32'sh7fffffff, 1'b1, '{32'sd0, 8'd1, ale_pkg::ST_OK}},
    '{ale_pkg::CMD_REVERSE, 7'd127, 32'sh55555555, 1'b1, '{32'sd0, 8'd1, ale_pkg::ST_OK}},
    '{ale_pkg::CMD_READ,    7'd0,   32'sd0,        1'b1,
      '{32'sh7fffffff, 8'd1, ale_pkg::ST_OK}},
    '{ale_pkg::CMD_INSERT,  7'd1,   32'sh80000000, 1'b1, '{32'sd0, 8'd2, ale_pkg::ST_OK}},
    '{ale_pkg::CMD_INSERT,  7'd0,   -32'sd1,       1'b0, UNTYPED},
    '{ale_pkg::CMD_INSERT,  7'd1,   32'sd0,        1'b0, UNTYPED},
    '{ale_pkg::CMD_READ,    7'd3,   32'shaaaaaaaa, 1'b1,
      '{32'sh80000000, 8'd4, ale_pkg::ST_OK}},
    '{ale_pkg::CMD_READ,    7'd4,   32'sd0,        1'b1, '{32'sd0, 8'd4, ale_pkg::ST_RANGE}},
    '{ale_pkg::CMD_INSERT,  7'd6,   32'sd1,        1'b1, '{32'sd0, 8'd4, ale_pkg::ST_RANGE}},
    '{ale_pkg::CMD_REVERSE, 7'd42,  32'sd0,        1'b0, UNTYPED},
    '{ale_pkg::CMD_READ,    7'd0,   32'sd0,        1'b0, UNTYPED},
    '{ale_pkg::CMD_REMOVE,  7'd1,   32'sd0,        1'b0, UNTYPED},
    '{ale_pkg::CMD_REMOVE,  7'd3,   32'sd0,        1'b1, '{32'sd0, 8'd3, ale_pkg::ST_RANGE}},
    '{ale_pkg::CMD_INSERT,  7'd3,   32'sh5a5a5a5a, 1'b0, UNTYPED},
    '{ale_pkg::CMD_REVERSE, 7'd0,   32'sd0,        1'b0, UNTYPED},
    '{ale_pkg::CMD_REMOVE,  7'd0,   32'sd0,        1'b0, UNTYPED},
    '{ale_pkg::CMD_READ,    7'd127, 32'sd0,        1'b1, '{32'sd0, 8'd3, ale_pkg::ST_RANGE}},
    '{ale_pkg::CMD_REMOVE,  7'd2,   32'sd0,        1'b0, UNTYPED},
    '{ale_pkg::CMD_REMOVE,  7'd127, 32'sh12345678, 1'b1, '{32'sd0, 8'd2, ale_pkg::ST_RANGE}},
    '{ale_pkg::CMD_READ,    7'd1,   32'sd0,        1'b0, UNTYPED}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_command;
  logic [6:0]         in_position;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_data_out;
  logic [7:0]         out_count;
  logic [1:0]         out_status;

  logic signed [31:0] shadow_list [DEPTH];
  int                 shadow_count;
  list_result_t       predicted_list_replies [$];

  int cycle_count = 0;
  int errors = 0;
  int replies_checked = 0;
  int cmd_seen [4] = '{0, 0, 0, 0};
  int full_hits = 0;
  int range_hits = 0;
  int peak_count = 0;
  bit hold_request = 1'b0;

  array_list_engine_top #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_position  (in_position),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_count    (out_count),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("array_list_engine_top regression: fail");
      $finish;
    end
  end

  function automatic list_result_t apply_list_command(input ale_pkg::cmd_t cmd,
                                                      input logic [6:0] pos,
                                                      input logic signed [31:0] val);
    list_result_t       res;
    logic signed [31:0] tmp;
    int                 j;
    res.data = '0;
    res.status = ale_pkg::ST_OK;
    case (cmd)
      ale_pkg::CMD_INSERT: begin
        if (pos > shadow_count) begin
          res.status = ale_pkg::ST_RANGE;
        end else if (shadow_count >= DEPTH) begin
          res.status = ale_pkg::ST_FULL;
        end else begin
          for (j = shadow_count; j > pos; j--) shadow_list[j] = shadow_list[j-1];
          shadow_list[pos] = val;
          shadow_count++;
        end
      end
      ale_pkg::CMD_REMOVE: begin
        if (pos >= shadow_count) begin
          res.status = ale_pkg::ST_RANGE;
        end else begin
          res.data = shadow_list[pos];
          for (j = pos + 1; j < shadow_count; j++) shadow_list[j-1] = shadow_list[j];
          shadow_count--;
        end
      end
      ale_pkg::CMD_REVERSE: begin
        for (j = 0; j < shadow_count / 2; j++) begin
          tmp = shadow_list[j];
          shadow_list[j] = shadow_list[shadow_count-1-j];
          shadow_list[shadow_count-1-j] = tmp;
        end
      end
      default: begin
        if (pos >= shadow_count) res.status = ale_pkg::ST_RANGE;
        else res.data = shadow_list[pos];
      end
    endcase
    res.count = shadow_count[7:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // hold the beat until taken, then log what the list should answer
  task automatic offer_beat(input ale_pkg::cmd_t cmd, input logic [6:0] pos,
                            input logic signed [31:0] val, input logic typed,
                            input list_result_t typed_res);
    list_result_t predicted;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_position <= pos;
    in_value <= val;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_command(cmd, pos, val);
    predicted_list_replies.push_back(typed ? typed_res : predicted);
    cmd_seen[cmd]++;
    if (predicted.status == ale_pkg::ST_FULL) full_hits++;
    if (predicted.status == ale_pkg::ST_RANGE) range_hits++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic random_beat(input bit filling);
    int                 r;
    int                 insert_end;
    ale_pkg::cmd_t      cmd;
    logic [6:0]         pos;
    r = $urandom_range(99);
    insert_end = filling ? 70 : 18;
    pos = 7'($urandom_range(127));
    if (r < 8) begin
      cmd = ale_pkg::cmd_t'($urandom_range(3));
    end else if (r < insert_end) begin
      cmd = ale_pkg::CMD_INSERT;
      pos = 7'($urandom_range(shadow_count > 127 ? 127 : shadow_count));
    end else if (r < 80) begin
      cmd = ale_pkg::CMD_REMOVE;
      if (shadow_count > 0) pos = 7'($urandom_range(shadow_count - 1));
    end else if (r < 93) begin
      cmd = ale_pkg::CMD_READ;
      if (shadow_count > 0) pos = 7'($urandom_range(shadow_count - 1));
    end else begin
      cmd = ale_pkg::CMD_REVERSE;
    end
    offer_beat(cmd, pos, pick_value(), 1'b0, UNTYPED);
  endtask

  initial begin
    int sel;
    int idle;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        idle = pick_gap();
        if (idle > 0) begin
          out_stall <= 1'b1;
          repeat (idle) @(negedge clk);
        end
        out_stall <= 1'b0;
        sel = $urandom_range(9);
        repeat (sel == 0 ? $urandom_range(60, 20) : $urandom_range(4, 1)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_list_replies.size() == 0) begin
        $display("%0t: unexpected reply, data %0d count %0d status %0d",
                 $time, out_data_out, out_count, out_status);
        errors++;
      end else begin
        want = predicted_list_replies.pop_front();
        replies_checked++;
        if (out_data_out !== want.data) begin
          $display("%0t: data mismatch, expected %0d, got %0d", $time, want.data, out_data_out);
          errors++;
        end
        if (out_count !== want.count) begin
          $display("%0t: count mismatch, expected %0d, got %0d", $time, want.count, out_count);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    int i;
    bit filling;
    int full_mark;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = ale_pkg::CMD_INSERT;
    in_position = '0;
    in_value = '0;
    shadow_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < ROWS; i++) begin
      offer_beat(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].pos, DIRECTED_ROWS[i].val,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      idle_sender(pick_gap());
    end

    filling = 1'b1;
    full_mark = full_hits;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) hold_request = 1'b1;
      if (i == 500 || i == 1000) begin
        in_valid <= 1'b0;
        while (predicted_list_replies.size() != 0) @(negedge clk);
      end
      random_beat(filling);
      idle_sender(pick_gap());
      // drain once the full list has been hit a few times, refill when empty
      if (filling && full_hits >= full_mark + 4) filling = 1'b0;
      if (!filling && shadow_count == 0) begin
        filling = 1'b1;
        full_mark = full_hits;
      end
    end

    in_valid <= 1'b0;
    while (predicted_list_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d commands: insert %0d, remove %0d, reverse %0d, read %0d",
             cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
             cmd_seen[ale_pkg::CMD_INSERT], cmd_seen[ale_pkg::CMD_REMOVE],
             cmd_seen[ale_pkg::CMD_REVERSE], cmd_seen[ale_pkg::CMD_READ]);
    $display("%0d replies checked, list peaked at %0d entries, %0d full rejections,",
             replies_checked, peak_count, full_hits);
    $display("%0d position errors, %0d mismatches", range_hits, errors);
    if (errors == 0) begin
      $display("array_list_engine_top regression: pass");
    end else begin
      $display("array_list_engine_top regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/ale_pkg.sv
sv/array_list_engine_top.sv
sv/ale_checker.sv
verif/array_list_engine_top_tb.sv
